// File: rtl/gvc_pkg.sv
// ----------------------------------------------------------------------------
// gvc_pkg
// Shared types and constants of the greedy vertex-cut edge assigner.
// ----------------------------------------------------------------------------
package gvc_pkg;

  localparam int NODE_ID_W  = 16;
  localparam int WEIGHT_IN_W = 16;
  localparam int DEGREE_W   = 24;
  localparam int RANDOM_W   = 16;
  localparam int PART_OUT_W = 4;
  localparam int CASE_W     = 3;
  localparam int EDGE_W     = 32;
  localparam int WEIGHT_W   = 48;
  localparam int CFG_W      = 5;
  // remainder register of the tie-pick divider: tie count up to 128, shifted
  localparam int DIV_REM_W  = 8;
  localparam int DIV_STEP_W = 4;

  localparam logic [CASE_W-1:0] CASE_BOTH_NEW   = 3'd0;
  localparam logic [CASE_W-1:0] CASE_FOLLOW_SRC = 3'd1;
  localparam logic [CASE_W-1:0] CASE_FOLLOW_DST = 3'd2;
  localparam logic [CASE_W-1:0] CASE_SHARED     = 3'd3;
  localparam logic [CASE_W-1:0] CASE_SPLIT      = 3'd4;

  typedef struct packed {
    logic     clr_step;
    logic     load;
    logic     wrap_q;
    logic     wrap_r;
    logic     div_start;
    logic     div_step;
    logic     cap_mask;
    logic     scan1_step;
    logic     scan2_step;
    logic     update;
    logic     wr2;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic div_last;
    logic scan_last;
    logic pick_hit;
    logic out_free;
    logic is_both_new;
  } dp_sts_t;

endpackage

// File: rtl/gvc_in_if.sv
// ----------------------------------------------------------------------------
// gvc_in_if
// Edge input channel: valid/ready handshake with the edge payload.
// ----------------------------------------------------------------------------
interface gvc_in_if;
  logic                             valid;
  logic                             ready;
  logic [gvc_pkg::NODE_ID_W-1:0]    src_node;
  logic [gvc_pkg::NODE_ID_W-1:0]    dst_node;
  logic [gvc_pkg::WEIGHT_IN_W-1:0]  edge_weight;
  logic [gvc_pkg::DEGREE_W-1:0]     src_degree;
  logic [gvc_pkg::DEGREE_W-1:0]     dst_degree;
  logic [gvc_pkg::RANDOM_W-1:0]     tie_random;

  modport source (output valid, src_node, dst_node, edge_weight, src_degree, dst_degree,
                  tie_random, input ready);
  modport sink (input valid, src_node, dst_node, edge_weight, src_degree, dst_degree,
                tie_random, output ready);
endinterface

// File: rtl/gvc_out_if.sv
// ----------------------------------------------------------------------------
// gvc_out_if
// Result channel: valid/ready handshake with the assignment result.
// ----------------------------------------------------------------------------
interface gvc_out_if;
  logic                            valid;
  logic                            ready;
  logic [gvc_pkg::PART_OUT_W-1:0]  assigned_partition;
  logic [gvc_pkg::CASE_W-1:0]      assign_case;
  logic                            replicated;
  logic [gvc_pkg::NODE_ID_W-1:0]   replicated_node;
  logic [gvc_pkg::EDGE_W-1:0]      partition_edges;
  logic [gvc_pkg::WEIGHT_W-1:0]    partition_weight;

  modport source (output valid, assigned_partition, assign_case, replicated,
                  replicated_node, partition_edges, partition_weight, input ready);
  modport sink (input valid, assigned_partition, assign_case, replicated,
                replicated_node, partition_edges, partition_weight, output ready);
endinterface

// File: rtl/gvc_ram.sv
// ----------------------------------------------------------------------------
// gvc_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module gvc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// File: rtl/gvc_dp.sv
// ----------------------------------------------------------------------------
// gvc_dp
// Datapath: node mask memory, partition counters, node wrap, tie divider,
// scan registers and the result register.
// ----------------------------------------------------------------------------
module gvc_dp #(
  parameter int MAX_PARTS = 16,
  parameter int NODES     = 65536
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  gvc_pkg::dp_cmd_t                cmd,
  output gvc_pkg::dp_sts_t                sts,
  input  logic                            cfg_we,
  input  logic [gvc_pkg::CFG_W-1:0]       cfg_data,
  input  logic [gvc_pkg::NODE_ID_W-1:0]   src_node,
  input  logic [gvc_pkg::NODE_ID_W-1:0]   dst_node,
  input  logic [gvc_pkg::WEIGHT_IN_W-1:0] edge_weight,
  input  logic [gvc_pkg::DEGREE_W-1:0]    src_degree,
  input  logic [gvc_pkg::DEGREE_W-1:0]    dst_degree,
  input  logic [gvc_pkg::RANDOM_W-1:0]    tie_random,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic [gvc_pkg::PART_OUT_W-1:0]  assigned_partition,
  output logic [gvc_pkg::CASE_W-1:0]      assign_case,
  output logic                            replicated,
  output logic [gvc_pkg::NODE_ID_W-1:0]   replicated_node,
  output logic [gvc_pkg::EDGE_W-1:0]      partition_edges,
  output logic [gvc_pkg::WEIGHT_W-1:0]    partition_weight
);
  import gvc_pkg::*;

  localparam int NW = $clog2(NODES);
  localparam int PW = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;
  localparam int CW = $clog2(MAX_PARTS + 1);
  localparam int PC = (MAX_PARTS > 31) ? MAX_PARTS : 31;
  localparam int PCW = $clog2(PC + 1);

  // node wrap: q = (id * RECIP) >> 32 is the true quotient or one short
  localparam int RECIP_SH = 32;
  localparam int PROD_W   = NODE_ID_W + RECIP_SH;
  localparam longint unsigned RECIP = (64'd1 << RECIP_SH) / 64'(NODES);
  localparam logic [31:0] RECIP_K = 32'(RECIP);

  // configuration
  logic [CFG_W-1:0] parts_r;

  // latched item
  logic [NODE_ID_W-1:0]   src_r, dst_r;
  logic [WEIGHT_IN_W-1:0] wgt_r;
  logic [DEGREE_W-1:0]    du_r, dv_r;
  logic [RANDOM_W-1:0]    rnd_r;
  logic [NW-1:0]          u_r, v_r;

  // node wrap
  logic [NODE_ID_W-1:0] qu_r, qv_r;
  logic [PROD_W-1:0]    prod_u, prod_v;
  logic [31:0]          rem_u, rem_v, wrap_u, wrap_v;

  // divider
  logic [DIV_REM_W-1:0]  rem_r, rem_nxt, rem_sh, dsr;
  logic [RANDOM_W-1:0]   dvd_r;
  logic [DIV_STEP_W-1:0] div_cnt_r;

  // classification
  logic [MAX_PARTS-1:0] mu, mv, cand_r, base_r, ties_r, lowm, onehot_c, onehot_i;
  logic [CASE_W-1:0]    case_r;
  logic                 rep_r, wen1_r;
  logic [NW-1:0]        wa1_r, rnode_r;
  logic [PCW-1:0]       eff;

  // scans
  logic [PW-1:0]        scan_i_r, c_r;
  logic [EDGE_W:0]      best_r;
  logic [CW-1:0]        count_r, seen_r, pick_r;

  // counters
  logic [EDGE_W-1:0]    cnt_r [MAX_PARTS];
  logic [WEIGHT_W-1:0]  wsum_r [MAX_PARTS];
  logic [EDGE_W-1:0]    cnt_new;
  logic [WEIGHT_W:0]    wsum_add;
  logic [WEIGHT_W-1:0]  wsum_new;

  // memory
  logic [NW-1:0]        clr_cnt_r, waddr;
  logic                 we;
  logic [MAX_PARTS-1:0] wdata, rdata_a, rdata_b;

  logic                 out_valid_r;
  logic                 u_less;

  gvc_ram #(.WIDTH(MAX_PARTS), .DEPTH(NODES)) u_mask_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (u_r),
    .rdata_a (rdata_a),
    .raddr_b (v_r),
    .rdata_b (rdata_b)
  );

  assign mu     = rdata_a;
  assign mv     = rdata_b;
  assign u_less = du_r < dv_r;

  always_comb begin
    onehot_c = '0;
    onehot_c[c_r] = 1'b1;
    onehot_i = '0;
    onehot_i[scan_i_r] = 1'b1;
  end

  // memory write port: clearing pass, then first and second mask writes
  always_comb begin
    we    = 1'b0;
    waddr = wa1_r;
    wdata = base_r | onehot_c;
    if (cmd.clr_step) begin
      we    = 1'b1;
      waddr = clr_cnt_r;
      wdata = '0;
    end else if (cmd.update) begin
      we    = wen1_r;
    end else if (cmd.wr2) begin
      we    = 1'b1;
      waddr = v_r;
      wdata = onehot_c;
    end
  end

  // node wrap: the quotient is registered first, then the wrapped remainder
  always_comb begin
    prod_u = PROD_W'(src_r) * PROD_W'(RECIP_K);
    prod_v = PROD_W'(dst_r) * PROD_W'(RECIP_K);
    rem_u  = 32'(src_r) - 32'(qu_r) * 32'(NODES);
    rem_v  = 32'(dst_r) - 32'(qv_r) * 32'(NODES);
    wrap_u = (rem_u >= 32'(NODES)) ? rem_u - 32'(NODES) : rem_u;
    wrap_v = (rem_v >= 32'(NODES)) ? rem_v - 32'(NODES) : rem_v;
  end

  // one restoring division step
  always_comb begin
    dsr     = DIV_REM_W'(count_r);
    rem_sh  = {rem_r[DIV_REM_W-2:0], dvd_r[RANDOM_W-1]};
    rem_nxt = (rem_sh >= dsr) ? rem_sh - dsr : rem_sh;
  end

  // effective partition count and the all-candidates mask
  always_comb begin
    if (parts_r == '0) begin
      eff = PCW'(1);
    end else if (PCW'(parts_r) > PCW'(MAX_PARTS)) begin
      eff = PCW'(MAX_PARTS);
    end else begin
      eff = PCW'(parts_r);
    end
    for (int i = 0; i < MAX_PARTS; i++) begin
      lowm[i] = PCW'(i) < eff;
    end
  end

  always_comb begin
    cnt_new  = (cnt_r[c_r] == '1) ? cnt_r[c_r] : cnt_r[c_r] + EDGE_W'(1);
    wsum_add = {1'b0, wsum_r[c_r]} + (WEIGHT_W + 1)'(wgt_r);
    wsum_new = wsum_add[WEIGHT_W] ? '1 : wsum_add[WEIGHT_W-1:0];
  end

  assign sts.clr_last    = clr_cnt_r == NW'(NODES - 1);
  assign sts.div_last    = div_cnt_r == '1;
  assign sts.scan_last   = scan_i_r == PW'(MAX_PARTS - 1);
  assign sts.pick_hit    = ties_r[scan_i_r] && (seen_r == pick_r);
  assign sts.out_free    = !out_valid_r || out_ready;
  assign sts.is_both_new = case_r == CASE_BOTH_NEW;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      parts_r     <= CFG_W'(16);
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < MAX_PARTS; i++) begin
        cnt_r[i]  <= '0;
        wsum_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        parts_r <= cfg_data;
      end
      if (cmd.clr_step) begin
        clr_cnt_r <= clr_cnt_r + NW'(1);
      end
      if (cmd.update) begin
        cnt_r[c_r]  <= cnt_new;
        wsum_r[c_r] <= wsum_new;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      src_r <= src_node;
      dst_r <= dst_node;
      wgt_r <= edge_weight;
      du_r  <= src_degree;
      dv_r  <= dst_degree;
      rnd_r <= tie_random;
    end

    if (cmd.wrap_q) begin
      qu_r <= prod_u[PROD_W-1:RECIP_SH];
      qv_r <= prod_v[PROD_W-1:RECIP_SH];
    end
    if (cmd.wrap_r) begin
      u_r <= NW'(wrap_u);
      v_r <= NW'(wrap_v);
    end

    if (cmd.div_step && sts.div_last) begin
      pick_r <= rem_nxt[CW-1:0];
    end
    if (cmd.div_start) begin
      div_cnt_r <= '0;
      rem_r     <= '0;
      dvd_r     <= rnd_r;
    end else if (cmd.div_step) begin
      div_cnt_r <= div_cnt_r + DIV_STEP_W'(1);
      rem_r     <= rem_nxt;
      dvd_r     <= {dvd_r[RANDOM_W-2:0], 1'b0};
    end

    if (cmd.cap_mask) begin
      scan_i_r <= '0;
      best_r   <= '1;
      ties_r   <= '0;
      count_r  <= '0;
      seen_r   <= '0;
      if (mu == '0 && mv == '0) begin
        case_r  <= CASE_BOTH_NEW;
        cand_r  <= lowm;
        wa1_r   <= u_r;
        base_r  <= mu;
        rep_r   <= 1'b0;
        rnode_r <= '0;
        wen1_r  <= 1'b1;
      end else if (mv == '0) begin
        case_r  <= CASE_FOLLOW_SRC;
        cand_r  <= mu;
        wa1_r   <= v_r;
        base_r  <= mv;
        rep_r   <= 1'b0;
        rnode_r <= '0;
        wen1_r  <= 1'b1;
      end else if (mu == '0) begin
        case_r  <= CASE_FOLLOW_DST;
        cand_r  <= mv;
        wa1_r   <= u_r;
        base_r  <= mu;
        rep_r   <= 1'b0;
        rnode_r <= '0;
        wen1_r  <= 1'b1;
      end else if ((mu & mv) != '0) begin
        case_r  <= CASE_SHARED;
        cand_r  <= mu & mv;
        wa1_r   <= u_r;
        base_r  <= mu;
        rep_r   <= 1'b0;
        rnode_r <= '0;
        wen1_r  <= 1'b0;
      end else begin
        // split: lower-degree end's mask, the other end gains a copy
        case_r  <= CASE_SPLIT;
        rep_r   <= 1'b1;
        cand_r  <= u_less ? mu : mv;
        wa1_r   <= u_less ? v_r : u_r;
        rnode_r <= u_less ? v_r : u_r;
        base_r  <= u_less ? mv : mu;
        wen1_r  <= 1'b1;
      end
    end

    if (cmd.scan1_step) begin
      scan_i_r <= sts.scan_last ? '0 : scan_i_r + PW'(1);
      if (cand_r[scan_i_r]) begin
        if ({1'b0, cnt_r[scan_i_r]} < best_r) begin
          best_r  <= {1'b0, cnt_r[scan_i_r]};
          ties_r  <= onehot_i;
          count_r <= CW'(1);
        end else if ({1'b0, cnt_r[scan_i_r]} == best_r) begin
          ties_r  <= ties_r | onehot_i;
          count_r <= count_r + CW'(1);
        end
      end
    end

    if (cmd.scan2_step) begin
      scan_i_r <= scan_i_r + PW'(1);
      if (ties_r[scan_i_r]) begin
        seen_r <= seen_r + CW'(1);
      end
      if (sts.pick_hit) begin
        c_r <= scan_i_r;
      end
    end

    if (cmd.update) begin
      assigned_partition <= PART_OUT_W'(c_r);
      assign_case        <= case_r;
      replicated         <= rep_r;
      replicated_node    <= NODE_ID_W'(rnode_r);
      partition_edges    <= cnt_new;
      partition_weight   <= wsum_new;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// File: rtl/gvc_ctrl.sv
// ----------------------------------------------------------------------------
// gvc_ctrl
// Controller: sequences clearing, node wrap, mask read, scans, tie division and update.
// ----------------------------------------------------------------------------
module gvc_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output gvc_pkg::dp_cmd_t cmd,
  input  gvc_pkg::dp_sts_t sts
);
  import gvc_pkg::*;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WRAP_Q,
    ST_WRAP_R,
    ST_READ,
    ST_CAP,
    ST_SCAN1,
    ST_DIV_R,
    ST_SCAN2,
    ST_UPD,
    ST_WR2
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_WRAP_Q;
        end
      end
      ST_WRAP_Q: begin
        cmd.wrap_q = 1'b1;
        state_nxt  = ST_WRAP_R;
      end
      ST_WRAP_R: begin
        cmd.wrap_r = 1'b1;
        state_nxt  = ST_READ;
      end
      ST_READ: state_nxt = ST_CAP;
      ST_CAP: begin
        cmd.cap_mask = 1'b1;
        state_nxt    = ST_SCAN1;
      end
      ST_SCAN1: begin
        cmd.scan1_step = 1'b1;
        if (sts.scan_last) begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_DIV_R;
        end
      end
      ST_DIV_R: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = ST_SCAN2;
      end
      ST_SCAN2: begin
        cmd.scan2_step = 1'b1;
        if (sts.pick_hit) state_nxt = ST_UPD;
      end
      ST_UPD: begin
        if (sts.out_free) begin
          cmd.update = 1'b1;
          state_nxt  = sts.is_both_new ? ST_WR2 : ST_IDLE;
        end
      end
      ST_WR2: begin
        cmd.wr2   = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: rtl/greedy_vertex_cut_edge_assigner.sv
// ----------------------------------------------------------------------------
// greedy_vertex_cut_edge_assigner
// Assigns streamed edges to partitions by a greedy vertex-cut rule.
// ----------------------------------------------------------------------------
// Each accepted edge passes the node-wrap quotient and remainder states, the
// mask read and capture, the first partition scan, the 16-step tie divider,
// the second scan and the update, and a second mask write when both ends are
// new; no edge is taken before that. The next item is taken while a result
// waits in the output register; its update stalls until that result leaves.
// Reset: synchronous; a clearing pass zeroes all NODES mask memory words.
module greedy_vertex_cut_edge_assigner #(
  parameter int MAX_PARTS = 16,
  parameter int NODES     = 65536
) (
  input  logic                       clk,
  input  logic                       rst_n,
  gvc_in_if.sink                     in_ch,
  gvc_out_if.source                  out_ch,
  input  logic                       cfg_we,
  input  logic [gvc_pkg::CFG_W-1:0]  cfg_data
);
  import gvc_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  gvc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  gvc_dp #(.MAX_PARTS(MAX_PARTS), .NODES(NODES)) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .cfg_we             (cfg_we),
    .cfg_data           (cfg_data),
    .src_node           (in_ch.src_node),
    .dst_node           (in_ch.dst_node),
    .edge_weight        (in_ch.edge_weight),
    .src_degree         (in_ch.src_degree),
    .dst_degree         (in_ch.dst_degree),
    .tie_random         (in_ch.tie_random),
    .out_ready          (out_ch.ready),
    .out_valid          (out_ch.valid),
    .assigned_partition (out_ch.assigned_partition),
    .assign_case        (out_ch.assign_case),
    .replicated         (out_ch.replicated),
    .replicated_node    (out_ch.replicated_node),
    .partition_edges    (out_ch.partition_edges),
    .partition_weight   (out_ch.partition_weight)
  );

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("input taken while an item is in work");

  a_rep_only_split: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.replicated == (out_ch.assign_case == CASE_SPLIT)))
    else $error("replicated flag disagrees with split case");

  a_part_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (MAX_PARTS > 16 || out_ch.assigned_partition < MAX_PARTS))
    else $error("partition index out of range");

  a_edges_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.partition_edges != 0)
    else $error("chosen partition reports no edges");
`endif

endmodule

// File: tb/gvc_test_if.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gvc_test_if
// Holder for the testbench's idle and hold-off knobs.
// ----------------------------------------------------------------------------
interface gvc_test_if;
  int src_idle_pct = 0;
  int snk_stall_pct = 0;
  bit long_hold = 0;
endinterface

// File: tb/greedy_vertex_cut_edge_assigner_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Greedy vertex-cut edge assigner test
// Drives directed and random edges through the block under varied source
// idling and sink stalls, predicts each assignment and checks every result.
// ----------------------------------------------------------------------------
class part_scoreboard;
  bit [15:0] node_mask [int];
  bit [31:0] edge_cnt [16];
  bit [47:0] weight_sum [16];
  bit [4:0]  parts_cfg;
  typedef struct packed {
    bit [3:0]  part;
    bit [2:0]  kase;
    bit        rep;
    bit [15:0] rnode;
    bit [31:0] edges;
    bit [47:0] weight;
  } assign_t;
  assign_t pending [$];
  int errors;

  function new();
    parts_cfg = 5'd16;
    errors = 0;
  endfunction

  function bit [15:0] mask_of(bit [15:0] n);
    return node_mask.exists(n) ? node_mask[n] : 16'h0;
  endfunction

  function void note_edge(bit [15:0] u, bit [15:0] v, bit [15:0] w,
                          bit [23:0] du, bit [23:0] dv, bit [15:0] rnd);
    bit [15:0] mu, mv, cand, ties;
    bit [31:0] best;
    int np, cnt, pick, seen, c;
    bit first;
    assign_t r;
    mu = mask_of(u);
    mv = mask_of(v);
    np = (parts_cfg == 0) ? 1 : (parts_cfg > 16 ? 16 : parts_cfg);
    r = '0;
    if (mu == 0 && mv == 0) begin
      r.kase = gvc_pkg::CASE_BOTH_NEW; cand = 16'((32'h1 << np) - 1);
    end else if (mv == 0) begin
      r.kase = gvc_pkg::CASE_FOLLOW_SRC; cand = mu;
    end else if (mu == 0) begin
      r.kase = gvc_pkg::CASE_FOLLOW_DST; cand = mv;
    end else if ((mu & mv) != 0) begin
      r.kase = gvc_pkg::CASE_SHARED; cand = mu & mv;
    end else begin
      r.kase = gvc_pkg::CASE_SPLIT; cand = (du < dv) ? mu : mv;
    end
    first = 1; ties = 0; cnt = 0; best = '1;
    for (int i = 0; i < 16; i++) begin
      if (cand[i]) begin
        if (first || edge_cnt[i] < best) begin
          best = edge_cnt[i]; ties = 0; cnt = 0; first = 0;
        end
        if (edge_cnt[i] == best) begin
          ties[i] = 1; cnt++;
        end
      end
    end
    c = 0;
    pick = rnd % cnt;
    seen = 0;
    for (int i = 0; i < 16; i++) begin
      if (ties[i]) begin
        if (seen == pick) c = i;
        seen++;
      end
    end
    case (r.kase)
      gvc_pkg::CASE_BOTH_NEW: begin
        node_mask[u] = mu | (16'h1 << c);
        node_mask[v] = mask_of(v) | (16'h1 << c);
      end
      gvc_pkg::CASE_FOLLOW_SRC: node_mask[v] = mv | (16'h1 << c);
      gvc_pkg::CASE_FOLLOW_DST: node_mask[u] = mu | (16'h1 << c);
      gvc_pkg::CASE_SPLIT: begin
        r.rep = 1;
        if (du < dv) begin
          node_mask[v] = mv | (16'h1 << c); r.rnode = v;
        end else begin
          node_mask[u] = mu | (16'h1 << c); r.rnode = u;
        end
      end
      default: ;
    endcase
    if (edge_cnt[c] != '1) edge_cnt[c]++;
    if ({1'b0, weight_sum[c]} + w > 49'h0FFFF_FFFF_FFFF) weight_sum[c] = '1;
    else weight_sum[c] = weight_sum[c] + w;
    r.part = 4'(c);
    r.edges = edge_cnt[c];
    r.weight = weight_sum[c];
    pending = {pending, r};
  endfunction

  function void check_result(assign_t got);
    assign_t exp;
    if (pending.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result %p", got);
      return;
    end
    exp = pending.pop_front();
    if (got !== exp) begin
      errors++;
      if (errors <= 10) $display("mismatch: expected %p, got %p", exp, got);
    end
  endfunction
endclass

module greedy_vertex_cut_edge_assigner_test;
  import gvc_pkg::*;

  localparam int HOLD_OFF = 600;
  localparam int WATCHDOG = 200000;

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic [CFG_W-1:0] cfg_data = '0;
  gvc_in_if in_ch();
  gvc_out_if out_ch();
  gvc_test_if knobs();

  greedy_vertex_cut_edge_assigner DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  part_scoreboard sb = new();
  int idle_cycles = 0;
  int hold_left = 0;
  bit hold_done = 0;
  bit [15:0] node_pool [8];

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  // sink: stalls at random, plus one long hold-off on request
  always @(negedge clk) begin
    if (knobs.long_hold && !hold_done && hold_left == 0) begin
      hold_left <= HOLD_OFF;
      hold_done <= 1'b1;
    end
    if (hold_left > 0) begin
      out_ch.ready <= 0;
      hold_left <= hold_left - 1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= knobs.snk_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result({out_ch.assigned_partition, out_ch.assign_case, out_ch.replicated,
                       out_ch.replicated_node, out_ch.partition_edges,
                       out_ch.partition_weight});
    if ((rst_n && in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else if (rst_n)
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_edge(bit [15:0] u, bit [15:0] v, bit [15:0] w,
                           bit [23:0] du, bit [23:0] dv, bit [15:0] rnd);
    while ($urandom_range(99) < knobs.src_idle_pct) @(negedge clk);
    in_ch.valid = 1;
    in_ch.src_node = u; in_ch.dst_node = v; in_ch.edge_weight = w;
    in_ch.src_degree = du; in_ch.dst_degree = dv; in_ch.tie_random = rnd;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_edge(u, v, w, du, dv, rnd);
    @(negedge clk);
    in_ch.valid = 0;
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (120) @(negedge clk);
  endtask

  task automatic write_parts(bit [4:0] n);
    cfg_we <= 1; cfg_data <= n;
    @(negedge clk);
    cfg_we <= 0;
    sb.parts_cfg = n;
  endtask

  function automatic bit [15:0] pick_node();
    return ($urandom_range(3) == 0) ? 16'($urandom) : node_pool[$urandom_range(7)];
  endfunction

  task automatic random_edges(int count);
    for (int i = 0; i < count; i++)
      send_edge(pick_node(), pick_node(), 16'($urandom), 24'($urandom),
                ($urandom_range(5) == 0) ? 24'($urandom) : 24'($urandom_range(3)),
                16'($urandom));
  endtask

  initial begin
    in_ch.valid = 0;
    in_ch.src_node = 0; in_ch.dst_node = 0; in_ch.edge_weight = 0;
    in_ch.src_degree = 0; in_ch.dst_degree = 0; in_ch.tie_random = 0;
    foreach (node_pool[i]) node_pool[i] = 16'($urandom);
    repeat (8) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);
    // directed: extremes, every case, self loops, equal degrees, odd register values
    send_edge(16'h0000, 16'hFFFF, 16'hFFFF, 24'hFFFFFF, 24'h0, 16'hFFFF);
    send_edge(16'h0000, 16'h1234, 16'h0, 24'h0, 24'hFFFFFF, 16'h0);
    send_edge(16'h4321, 16'hFFFF, 16'h1, 24'h5, 24'h5, 16'h5);
    send_edge(16'h0007, 16'h0007, 16'h8000, 24'h1, 24'h1, 16'h7);
    send_edge(16'h0007, 16'h0007, 16'h7FFF, 24'h1, 24'h1, 16'h3);
    send_edge(16'h0000, 16'h0007, 16'hAAAA, 24'h3, 24'h3, 16'h1);
    send_edge(16'h0000, 16'h0007, 16'h5555, 24'h2, 24'h9, 16'h2);
    send_edge(16'hFFFF, 16'h0007, 16'h5555, 24'h800000, 24'h7FFFFF, 16'h2);
    send_edge(16'h0000, 16'hFFFF, 16'h1111, 24'h1, 24'h2, 16'h9);
    drain();
    write_parts(5'd0);
    send_edge(16'h0100, 16'h0101, 16'h10, 24'h1, 24'h1, 16'hFFFF);
    send_edge(16'h0102, 16'h0100, 16'h20, 24'h1, 24'h1, 16'h0);
    drain();
    write_parts(5'd31);
    send_edge(16'h0200, 16'h0201, 16'h30, 24'h1, 24'h1, 16'hABCD);
    drain();
    write_parts(5'd1);
    send_edge(16'h0300, 16'h0301, 16'h40, 24'h1, 24'h1, 16'h1);
    send_edge(16'h0300, 16'h0000, 16'h40, 24'h1, 24'h1, 16'h1);
    drain();
    // random phases under differing idle patterns and partition counts
    write_parts(5'd16);
    random_edges(90);
    drain();
    knobs.src_idle_pct = 59;
    write_parts(5'd4);
    random_edges(80);
    drain();
    knobs.src_idle_pct = 0; knobs.snk_stall_pct = 59;
    write_parts(5'd9);
    knobs.long_hold = 1;
    random_edges(80);
    drain();
    knobs.src_idle_pct = 31; knobs.snk_stall_pct = 31;
    write_parts(5'd2);
    random_edges(70);
    drain();
    knobs.src_idle_pct = 0; knobs.snk_stall_pct = 0;
    write_parts(5'd16);
    random_edges(70);
    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

// File: sim.f
rtl/gvc_pkg.sv
rtl/gvc_in_if.sv
rtl/gvc_out_if.sv
rtl/gvc_ram.sv
rtl/gvc_dp.sv
rtl/gvc_ctrl.sv
rtl/greedy_vertex_cut_edge_assigner.sv
tb/gvc_test_if.sv
tb/greedy_vertex_cut_edge_assigner_test.sv
